FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent check forms; clk and rst_n are taken from the using scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

FILE: rtl/pwms_pkg.sv
// ----------------------------------------------------------------------------
// pwms_pkg
// Types and constants of the weighted PCM mixer.
// ----------------------------------------------------------------------------
package pwms_pkg;

  // unity gain; a power of two, so the rescale is a shift
  localparam int VOLUME_ONE = 1024;
  localparam int VOL_SHIFT  = $clog2(VOLUME_ONE);
  localparam int VOL_HALF   = VOLUME_ONE / 2;

  localparam int SAMPLE_W = 32;
  localparam int DITHER_W = 10;
  localparam int WEIGHT_W = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = WEIGHT_W;

  // signed sample times zero-extended weight
  localparam int PROD_W = SAMPLE_W + WEIGHT_W + 1;
  // quotient after the rescale; also holds the 33-bit sum of add mode
  localparam int Q_W = PROD_W - VOL_SHIFT;

  typedef enum logic [1:0] {
    FMT_S8  = 2'd0,
    FMT_S16 = 2'd1,
    FMT_S24 = 2'd2,
    FMT_S32 = 2'd3
  } fmt_t;

  typedef enum logic {
    MODE_XFADE = 1'b0,
    MODE_ADD   = 1'b1
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORMAT = 2'd0,
    CFG_MODE   = 2'd1,
    CFG_WEIGHT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] data;
    logic                clip;
  } sat_res_t;

endpackage

FILE: rtl/pwms_in_if.sv
// ----------------------------------------------------------------------------
// pwms_in_if
// Sample-pair channel into the mixer: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface pwms_in_if import pwms_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_a;
  logic signed [SAMPLE_W-1:0] sample_b;
  logic signed [DITHER_W-1:0] dither;
  logic                       last_in;

  modport source (output valid, sample_a, sample_b, dither, last_in, input ready);
  modport sink   (input valid, sample_a, sample_b, dither, last_in, output ready);
endinterface

FILE: rtl/pwms_out_if.sv
// ----------------------------------------------------------------------------
// pwms_out_if
// Mixed-sample channel out of the mixer: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface pwms_out_if import pwms_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mixed;
  logic                       clipped;
  logic                       last_out;

  modport source (output valid, mixed, clipped, last_out, input ready);
  modport sink   (input valid, mixed, clipped, last_out, output ready);
endinterface

FILE: rtl/pwms_sat.sv
// ----------------------------------------------------------------------------
// pwms_sat
// Saturates a wide signed value to the signed range of the sample format.
// ----------------------------------------------------------------------------
module pwms_sat import pwms_pkg::*; (
  input  logic signed [Q_W-1:0] value,
  input  fmt_t                  fmt,
  output sat_res_t              res
);

  logic [5:0]            bits;
  logic signed [Q_W-1:0] lim_hi;
  logic signed [Q_W-1:0] lim_lo;

  always_comb begin
    unique case (fmt)
      FMT_S8:  bits = 6'd8;
      FMT_S16: bits = 6'd16;
      FMT_S24: bits = 6'd24;
      FMT_S32: bits = 6'd32;
      default: bits = 6'd32;
    endcase
  end

  assign lim_hi = (Q_W'(1) << (bits - 6'd1)) - Q_W'(1);
  assign lim_lo = ~lim_hi;

  always_comb begin
    priority if (value > lim_hi) begin
      res.data = lim_hi[SAMPLE_W-1:0];
      res.clip = 1'b1;
    end else if (value < lim_lo) begin
      res.data = lim_lo[SAMPLE_W-1:0];
      res.clip = 1'b1;
    end else begin
      res.data = value[SAMPLE_W-1:0];
      res.clip = 1'b0;
    end
  end

endmodule

FILE: rtl/pcm_weighted_mix_saturate.sv
// ----------------------------------------------------------------------------
// pcm_weighted_mix_saturate
// Crossfade or add two PCM streams, rescale the crossfade, then saturate to the format.
// ----------------------------------------------------------------------------
// Pipeline: input beat to output valid through the multiply, sum, rescale and
//   saturate stages, each stage one register.
// Throughput: one beat per cycle while the output accepts; per-stage ready lets
//   bubbles close up while the output is stalled.
// Reset: clears all stage valid bits; format = signed 16, crossfade mode,
//   weight = unity.
`include "assert_macros.svh"

module pcm_weighted_mix_saturate import pwms_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  pwms_in_if.sink               in_chan,
  pwms_out_if.source            out_chan
);

  // configuration
  fmt_t                fmt_r;
  mode_t               mode_r;
  logic [WEIGHT_W-1:0] weight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_S16;
      mode_r   <= MODE_XFADE;
      weight_r <= WEIGHT_W'(VOLUME_ONE);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_FORMAT: fmt_r    <= fmt_t'(cfg_wdata[1:0]);
        CFG_MODE:   mode_r   <= mode_t'(cfg_wdata[0]);
        CFG_WEIGHT: weight_r <= cfg_wdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage handshake
  logic v1_r, v2_r, v3_r, v4_r;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !v4_r || out_chan.ready;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_chan.ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_chan.valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  // stage 1: weights, products and the pair sum
  logic [WEIGHT_W-1:0]      w_a, w_b;
  logic signed [PROD_W-1:0] pa_nxt, pb_nxt;
  logic signed [PROD_W-1:0] pa1_r, pb1_r;
  logic signed [SAMPLE_W:0] sab1_r;
  logic signed [DITHER_W-1:0] d1_r;
  logic                     last1_r;

  assign w_a = (weight_r > WEIGHT_W'(VOLUME_ONE)) ? WEIGHT_W'(VOLUME_ONE) : weight_r;
  assign w_b = WEIGHT_W'(VOLUME_ONE) - w_a;
  assign pa_nxt = in_chan.sample_a * $signed({1'b0, w_a});
  assign pb_nxt = in_chan.sample_b * $signed({1'b0, w_b});

  always_ff @(posedge clk) begin
    if (adv1 && in_chan.valid) begin
      pa1_r   <= pa_nxt;
      pb1_r   <= pb_nxt;
      sab1_r  <= {in_chan.sample_a[SAMPLE_W-1], in_chan.sample_a}
               + {in_chan.sample_b[SAMPLE_W-1], in_chan.sample_b};
      d1_r    <= in_chan.dither;
      last1_r <= in_chan.last_in;
    end
  end

  // stage 2: accumulate with dither and rounding offset; add mode passes the pair sum
  logic signed [PROD_W-1:0] acc_nxt;
  logic signed [PROD_W-1:0] acc2_r;
  logic                     last2_r;

  always_comb begin
    if (mode_r == MODE_ADD) begin
      acc_nxt = {{(PROD_W-SAMPLE_W-1){sab1_r[SAMPLE_W]}}, sab1_r};
    end else begin
      acc_nxt = pa1_r + pb1_r
              + {{(PROD_W-DITHER_W){d1_r[DITHER_W-1]}}, d1_r}
              + PROD_W'(VOL_HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      acc2_r  <= acc_nxt;
      last2_r <= last1_r;
    end
  end

  // stage 3: divide by unity, truncating toward zero; add mode passes the sum
  logic signed [PROD_W-1:0] biased;
  logic signed [Q_W-1:0]    q_nxt;
  logic signed [Q_W-1:0]    q3_r;
  logic                     last3_r;

  assign biased = acc2_r[PROD_W-1] ? acc2_r + PROD_W'(VOLUME_ONE - 1) : acc2_r;
  assign q_nxt  = (mode_r == MODE_ADD) ? acc2_r[Q_W-1:0] : biased[PROD_W-1:VOL_SHIFT];

  always_ff @(posedge clk) begin
    if (adv3 && v2_r) begin
      q3_r    <= q_nxt;
      last3_r <= last2_r;
    end
  end

  // stage 4: saturate into the output register
  sat_res_t            sat;
  logic [SAMPLE_W-1:0] mixed4_r;
  logic                clip4_r;
  logic                last4_r;

  pwms_sat u_sat (
    .value (q3_r),
    .fmt   (fmt_r),
    .res   (sat)
  );

  always_ff @(posedge clk) begin
    if (adv4 && v3_r) begin
      mixed4_r <= sat.data;
      clip4_r  <= sat.clip;
      last4_r  <= last3_r;
    end
  end

  assign out_chan.valid    = v4_r;
  assign out_chan.mixed    = mixed4_r;
  assign out_chan.clipped  = clip4_r;
  assign out_chan.last_out = last4_r;

  `ASSERT_NEXT(a_s1_to_s2, v1_r && adv2, v2_r)
  `ASSERT_NEXT(a_s2_to_s3, v2_r && adv3, v3_r)
  `ASSERT_IMPLIES(a_ready_on_empty, !v1_r, in_chan.ready)
  `ASSERT_IMPLIES(a_add_fits, v3_r && (mode_r == MODE_ADD), q3_r[Q_W-1] == q3_r[Q_W-2])

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the weighted PCM mixer beat by beat. A local predictor tracks the
// register settings and computes the crossfade or add result with saturation.
// A directed set covers range edges, weight clamping, rounding toward zero and
// add mode. Random phases then run under changing settings, with random
// backpressure, one long output stall and one full drain pause.
// ----------------------------------------------------------------------------
module testbench import pwms_pkg::*; ();

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNMAPPED = 2'd3;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int PHASE_BEATS = 160;
  localparam int RAND_PHASES = 8;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample_a;
    logic signed [SAMPLE_W-1:0] sample_b;
    logic signed [DITHER_W-1:0] dither;
    logic                       last;
  } pair_beat_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] mixed;
    logic                       clipped;
    logic                       last;
  } mix_result_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pwms_in_if  in_chan ();
  pwms_out_if out_chan ();

  pcm_weighted_mix_saturate u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  // shadow of the block's registers
  fmt_t                cur_fmt;
  mode_t               cur_mode;
  logic [WEIGHT_W-1:0] cur_weight;

  pair_beat_t  pending_pairs[$];
  mix_result_t expected_mix[$];
  pair_beat_t  tx_beat;
  pair_beat_t  seen_beat;
  mix_result_t want;

  int   mismatch_count;
  int   tx_gap_left;
  int   rx_gap_left;
  logic tx_idle_on;
  logic rx_idle_on;
  logic rx_holding;
  event stall_ev;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic int pick_gap(input logic enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int format_bits(input fmt_t f);
    case (f)
      FMT_S8:  return 8;
      FMT_S16: return 16;
      FMT_S24: return 24;
      default: return 32;
    endcase
  endfunction

  function automatic mix_result_t predict_mix(input pair_beat_t p);
    longint sa, sb, sd, w, acc, hi, lo;
    mix_result_t r;
    sa = p.sample_a;
    sb = p.sample_b;
    sd = p.dither;
    if (cur_mode == MODE_ADD) begin
      acc = sa + sb;
    end else begin
      w = longint'(cur_weight);
      if (w > VOLUME_ONE) w = VOLUME_ONE;   // weight above unity clamps
      acc = sa * w + sb * (VOLUME_ONE - w) + sd + VOLUME_ONE / 2;
      acc = acc / VOLUME_ONE;               // truncates toward zero
    end
    hi = (longint'(1) << (format_bits(cur_fmt) - 1)) - 1;
    lo = -hi - 1;
    r.clipped = (acc > hi) || (acc < lo);
    if (acc > hi) acc = hi;
    if (acc < lo) acc = lo;
    r.mixed = acc[SAMPLE_W-1:0];
    r.last  = p.last;
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] gen_sample(input fmt_t f);
    int bits, k;
    logic signed [SAMPLE_W-1:0] t;
    longint hi;
    bits = format_bits(f);
    hi = (longint'(1) << (bits - 1)) - 1;
    k = $urandom_range(0, 19);
    t = $urandom();
    if (k < 13) begin
      // random value inside the format range
      t = t << (SAMPLE_W - bits);
      t = t >>> (SAMPLE_W - bits);
    end else if (k == 16) begin
      t = hi[SAMPLE_W-1:0];
    end else if (k == 17) begin
      t = ~hi[SAMPLE_W-1:0];
    end else if (k == 18) begin
      t = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    end else if (k == 19) begin
      t = $urandom_range(0, 8) - 4;
    end
    return t;
  endfunction

  task automatic push_pair(input logic signed [SAMPLE_W-1:0] a,
                           input logic signed [SAMPLE_W-1:0] b,
                           input logic signed [DITHER_W-1:0] d,
                           input logic last);
    pair_beat_t p;
    p.sample_a = a;
    p.sample_b = b;
    p.dither   = d;
    p.last     = last;
    pending_pairs.push_back(p);
  endtask

  task automatic push_random(input int count);
    for (int i = 0; i < count; i++) begin
      push_pair(gen_sample(cur_fmt), gen_sample(cur_fmt),
                DITHER_W'($urandom_range(0, 1023)),
                $urandom_range(0, 7) == 0);
    end
  endtask

  // sampled on the falling edge so all updates of the rising edge have settled
  task automatic wait_idle();
    @(negedge clk);
    while (pending_pairs.size() != 0 || in_chan.valid || expected_mix.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FORMAT: cur_fmt = fmt_t'(val[1:0]);
      CFG_MODE:   cur_mode = mode_t'(val[0]);
      CFG_WEIGHT: cur_weight = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input fmt_t f, input mode_t m, input logic [WEIGHT_W-1:0] w);
    wait_idle();
    write_reg(CFG_FORMAT, CFG_DATA_W'(f));
    write_reg(CFG_MODE, CFG_DATA_W'(m));
    write_reg(CFG_WEIGHT, w);
  endtask

  task automatic note_failure(input string msg);
    if (mismatch_count < 10) $display("%s", msg);
    mismatch_count++;
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      tx_gap_left   <= 0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (tx_gap_left != 0) begin
        in_chan.valid <= 1'b0;
        tx_gap_left   <= tx_gap_left - 1;
      end else if (pending_pairs.size() != 0) begin
        tx_beat = pending_pairs.pop_front();
        in_chan.valid    <= 1'b1;
        in_chan.sample_a <= tx_beat.sample_a;
        in_chan.sample_b <= tx_beat.sample_b;
        in_chan.dither   <= tx_beat.dither;
        in_chan.last_in  <= tx_beat.last;
        tx_gap_left      <= pick_gap(tx_idle_on);
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // long output stall, counted here
  initial begin
    rx_holding = 1'b0;
    forever begin
      @(stall_ev);
      @(posedge clk);
      rx_holding <= 1'b1;
      repeat (RX_HOLD_CYCLES) @(posedge clk);
      rx_holding <= 1'b0;
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      rx_gap_left    <= 0;
    end else if (rx_holding) begin
      out_chan.ready <= 1'b0;
    end else if (rx_gap_left != 0) begin
      out_chan.ready <= 1'b0;
      rx_gap_left    <= rx_gap_left - 1;
    end else begin
      out_chan.ready <= 1'b1;
      if (out_chan.valid && out_chan.ready) rx_gap_left <= pick_gap(rx_idle_on);
    end
  end

  // check results first, then record the accepted beat
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_mix.size() == 0) begin
          note_failure($sformatf("unexpected beat: mixed=%0d clip=%0b last=%0b",
                                 out_chan.mixed, out_chan.clipped, out_chan.last_out));
        end else begin
          want = expected_mix.pop_front();
          if (out_chan.mixed !== want.mixed || out_chan.clipped !== want.clipped ||
              out_chan.last_out !== want.last)
            note_failure($sformatf(
              "mix mismatch: exp mixed=%0d clip=%0b last=%0b got mixed=%0d clip=%0b last=%0b",
              want.mixed, want.clipped, want.last,
              out_chan.mixed, out_chan.clipped, out_chan.last_out));
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        seen_beat.sample_a = in_chan.sample_a;
        seen_beat.sample_b = in_chan.sample_b;
        seen_beat.dither   = in_chan.dither;
        seen_beat.last     = in_chan.last_in;
        expected_mix.push_back(predict_mix(seen_beat));
      end
    end
  end

  initial begin
    fmt_t  f;
    mode_t m;
    logic [WEIGHT_W-1:0] w;

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_addr         = '0;
    cfg_wdata        = '0;
    in_chan.valid    = 1'b0;
    in_chan.sample_a = '0;
    in_chan.sample_b = '0;
    in_chan.dither   = '0;
    in_chan.last_in  = 1'b0;
    out_chan.ready   = 1'b0;
    mismatch_count   = 0;
    tx_idle_on       = 1'b1;
    rx_idle_on       = 1'b1;
    cur_fmt          = FMT_S16;
    cur_mode         = MODE_XFADE;
    cur_weight       = WEIGHT_W'(VOLUME_ONE);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: signed 16, crossfade, unity weight
    push_pair(32'sd32767, -32'sd32768, 10'sd0, 1'b0);
    push_pair(32'sd40000, 32'sd0, 10'sd511, 1'b1);
    push_pair(32'sh7fff_ffff, 32'sh8000_0000, -10'sd512, 1'b0);
    push_pair(-32'sd32768, 32'sd5, -10'sd512, 1'b0);
    push_pair(-32'sd40000, 32'sd0, 10'sd0, 1'b0);
    wait_idle();
    // write to an unmapped index leaves the settings alone
    write_reg(CFG_IDX_UNMAPPED, '0);
    push_pair(32'sd1000, 32'sd0, 10'sd0, 1'b0);

    set_config(FMT_S32, MODE_XFADE, 11'd512);
    push_pair(32'sh7fff_ffff, 32'sh7fff_ffff, 10'sd511, 1'b0);
    push_pair(32'sh8000_0000, 32'sh8000_0000, -10'sd512, 1'b0);
    push_pair(-32'sd1, 32'sd0, -10'sd1, 1'b0);    // negative quotient rounds toward zero
    push_pair(32'sd0, -32'sd1, 10'sd0, 1'b1);

    set_config(FMT_S24, MODE_XFADE, 11'd2047);    // weight above unity
    push_pair(32'sd8388607, 32'sh8000_0000, 10'sd0, 1'b0);
    push_pair(32'sh00ff_ffff, 32'sd0, 10'sd0, 1'b0);

    set_config(FMT_S8, MODE_XFADE, 11'd0);
    push_pair(32'sh7fff_ffff, 32'sd127, 10'sd511, 1'b0);
    push_pair(32'sd0, -32'sd129, 10'sd0, 1'b0);

    set_config(FMT_S32, MODE_XFADE, 11'd1025);
    push_pair(32'sd5, 32'sh7fff_ffff, 10'sd0, 1'b0);

    set_config(FMT_S32, MODE_ADD, 11'd700);
    push_pair(32'sh7fff_ffff, 32'sh7fff_ffff, 10'sd0, 1'b0);
    push_pair(32'sh8000_0000, 32'sh8000_0000, 10'sd0, 1'b0);
    push_pair(32'sd100, -32'sd50, 10'sd511, 1'b1);  // dither has no effect here

    set_config(FMT_S8, MODE_ADD, 11'd700);
    push_pair(32'sd100, 32'sd100, 10'sd0, 1'b0);
    push_pair(-32'sd100, -32'sd100, 10'sd0, 1'b0);
    push_pair(32'sd127, 32'sd0, -10'sd512, 1'b0);

    set_config(FMT_S24, MODE_ADD, 11'd700);
    push_pair(32'sd8388607, 32'sd1, 10'sd0, 1'b0);
    push_pair(-32'sd8388608, 32'sd0, 10'sd0, 1'b0);

    set_config(FMT_S16, MODE_ADD, 11'd700);
    push_pair(-32'sd32768, -32'sd1, 10'sd0, 1'b0);
    push_pair(32'sd32767, 32'sd0, 10'sd0, 1'b1);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      f = fmt_t'(ph % 4);
      m = (ph % 8 < 5) ? MODE_XFADE : MODE_ADD;
      case ($urandom_range(0, 3))
        0:       w = '0;
        1:       w = WEIGHT_W'(VOLUME_ONE);
        2:       w = WEIGHT_W'($urandom_range(0, VOLUME_ONE));
        default: w = WEIGHT_W'($urandom_range(VOLUME_ONE + 1, 2047));
      endcase
      set_config(f, m, w);
      tx_idle_on = (ph != 2 && ph != 5);
      rx_idle_on = (ph != 5);
      if (ph == 2) begin
        // output held off while input keeps coming: the pipe fills and stalls
        push_random(PHASE_BEATS);
        -> stall_ev;
      end else if (ph == 4) begin
        push_random(PHASE_BEATS / 2);
        wait_idle();
        push_random(PHASE_BEATS / 2);
      end else begin
        push_random(PHASE_BEATS);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
